### rtl/sph_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sph_pkg;

  localparam int MOD_WIDTH = 31;
  localparam int MAX_LEN   = 1024;
  localparam int TBL_DEPTH = MAX_LEN + 1;
  localparam int IDX_W     = $clog2(TBL_DEPTH);
  localparam int BIT_W     = $clog2(MOD_WIDTH);

  localparam logic [MOD_WIDTH-1:0] BASE_RESET = MOD_WIDTH'(10042003);
  localparam logic [MOD_WIDTH-1:0] MOD_RESET  = MOD_WIDTH'(1000000007);

  localparam logic [1:0] REQ_START  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_RANGE = 2'd1;
  localparam logic [1:0] STS_FULL  = 2'd2;

  localparam logic CFG_BASE = 1'b0;
  localparam logic CFG_MOD  = 1'b1;

  typedef logic [MOD_WIDTH-1:0] word_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SB_RED, S_SB_SQ, S_SB_MUL, S_SB_END,
    S_AP_RD, S_AP_CAP, S_AP_RRP, S_AP_RP1, S_AP_RI, S_AP_TERM, S_AP_INV, S_AP_RPN,
    S_AP_WR,
    S_QR_RD1, S_QR_RD2, S_QR_CAP, S_QR_RHI, S_QR_RLO, S_QR_MUL,
    S_FIN
  } state_t;

  // Both operands must already be below m.
  function automatic word_t mod_add(input word_t x, input word_t y, input word_t m);
    logic [MOD_WIDTH:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[MOD_WIDTH-1:0];
  endfunction

  function automatic word_t mod_sub(input word_t x, input word_t y, input word_t m);
    logic [MOD_WIDTH:0] s;
    if (x >= y) s = {1'b0, x} - {1'b0, y};
    else        s = {1'b0, x} + {1'b0, m} - {1'b0, y};
    return s[MOD_WIDTH-1:0];
  endfunction

endpackage
`default_nettype wire

### rtl/sph_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module sph_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 1025
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

### rtl/sph_modmul.sv
`timescale 1ns / 1ps
`default_nettype none
module sph_modmul (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start_i,
  input  wire sph_pkg::word_t a_i,
  input  wire sph_pkg::word_t b_i,
  input  wire sph_pkg::word_t m_i,
  output logic              done_o,
  output sph_pkg::word_t    res_o
);
  import sph_pkg::*;

  // Shift-and-add, MSB first: each bit gets a doubling step, then a step that adds a when the bit is set.
  word_t             a_r, b_r, m_r, acc_r;
  word_t             acc_nxt;
  logic [BIT_W-1:0]  cnt_r, cnt_nxt;
  logic              phase_r, phase_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  always_comb begin
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    phase_nxt = phase_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (start_i) begin
      acc_nxt   = '0;
      cnt_nxt   = BIT_W'(MOD_WIDTH - 1);
      phase_nxt = 1'b0;
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      if (!phase_r) begin
        acc_nxt   = mod_add(acc_r, acc_r, m_r);
        phase_nxt = 1'b1;
      end else begin
        if (b_r[cnt_r]) acc_nxt = mod_add(acc_r, a_r, m_r);
        phase_nxt = 1'b0;
        if (cnt_r == '0) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (start_i) begin
      a_r <= a_i;
      b_r <= b_i;
      m_r <= m_i;
    end
  end

  assign done_o = done_r;
  assign res_o  = acc_r;

  a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && phase_r |-> acc_r < m_r) else $error("accumulator not reduced");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start_i |-> !busy_r) else $error("multiply started while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("done while still busy");

endmodule
`default_nettype wire

### rtl/substring_polynomial_hash_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Each request is one transaction; the block takes one at a time, in_stall is high meanwhile.
// Every modular multiply runs on one shared shift-and-add unit.
// Start: reduce the base, then the exponentiation: a square per bit of modulus-2, a multiply per one.
// Append: six multiplies; query: three; errors: none; a reserved type gives no result.
// Synchronous active-low reset restores registers and state; tables are not cleared, entry 0
// of each table is held in flops, other entries stay undefined until an append writes them.
module substring_polynomial_hash_top (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [1:0]                in_req_type,
  input  wire logic [7:0]                in_char_byte,
  input  wire logic [sph_pkg::IDX_W-1:0] in_left_index,
  input  wire logic [sph_pkg::IDX_W-1:0] in_right_index,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output sph_pkg::word_t                 out_hash_value,
  output logic [1:0]                     out_status,
  input  wire logic                      cfg_wr_en,
  input  wire logic                      cfg_index,
  input  wire sph_pkg::word_t            cfg_wdata
);
  import sph_pkg::*;

  state_t state_r, state_nxt;

  word_t hash_base_r, hash_modulus_r;
  word_t t0_r, t1_r, t2_r, t3_r, t0_nxt, t1_nxt, t2_nxt, t3_nxt;
  word_t rp_r, rp_nxt, binv_r, binv_nxt, inv0_r, inv0_nxt;
  word_t res_hv_r, res_hv_nxt, out_hash_r, out_hash_nxt;
  logic [1:0] res_st_r, res_st_nxt, out_status_r, out_status_nxt;
  logic out_valid_r, out_valid_nxt, issued_r, issued_nxt;
  logic pz_r, pz_nxt, iz_r, iz_nxt;
  logic [BIT_W-1:0] idx_r, idx_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic [IDX_W-1:0] l_r, l_nxt, rr_r, rr_nxt, len_r, len_nxt;

  word_t m_eff, one_m, expo, p_rd, i_rd, p_q, i_q, p_wdata, i_wdata, mul_a, mul_b, mul_res;
  logic in_acc, mul_state, mul_start, mul_done, can_load, q_ok;
  logic p_en, p_we, i_en, i_we;
  logic [IDX_W-1:0] p_addr, i_addr;

  assign m_eff    = (hash_modulus_r < MOD_WIDTH'(2)) ? MOD_WIDTH'(1) : hash_modulus_r;
  assign one_m    = (m_eff == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
  assign expo     = m_eff - MOD_WIDTH'(2);
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign can_load = !out_valid_r || !out_stall;
  assign q_ok     = (in_left_index != '0) && (in_left_index <= in_right_index) &&
                    (in_right_index <= len_r);
  assign p_rd     = pz_r ? '0 : p_q;
  assign i_rd     = iz_r ? inv0_r : i_q;
  assign mul_state = (state_r == S_SB_RED) || (state_r == S_SB_SQ) || (state_r == S_SB_MUL) ||
                     (state_r == S_AP_RRP) || (state_r == S_AP_RP1) || (state_r == S_AP_RI) ||
                     (state_r == S_AP_TERM) || (state_r == S_AP_INV) ||
                     (state_r == S_AP_RPN) || (state_r == S_QR_RHI) ||
                     (state_r == S_QR_RLO) || (state_r == S_QR_MUL);
  assign mul_start = mul_state && !issued_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_req_type)
            REQ_START:  state_nxt = S_SB_RED;
            REQ_APPEND: state_nxt = (len_r >= IDX_W'(MAX_LEN)) ? S_FIN : S_AP_RD;
            REQ_QUERY:  state_nxt = q_ok ? S_QR_RD1 : S_FIN;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_SB_RED:  if (mul_done) state_nxt = S_SB_SQ;
      S_SB_SQ: begin
        if (mul_done) begin
          if (expo[idx_r])        state_nxt = S_SB_MUL;
          else if (idx_r == '0)   state_nxt = S_SB_END;
        end
      end
      S_SB_MUL:  if (mul_done) state_nxt = (idx_r == '0) ? S_SB_END : S_SB_SQ;
      S_SB_END:  state_nxt = S_FIN;
      S_AP_RD:   state_nxt = S_AP_CAP;
      S_AP_CAP:  state_nxt = S_AP_RRP;
      S_AP_RRP:  if (mul_done) state_nxt = S_AP_RP1;
      S_AP_RP1:  if (mul_done) state_nxt = S_AP_RI;
      S_AP_RI:   if (mul_done) state_nxt = S_AP_TERM;
      S_AP_TERM: if (mul_done) state_nxt = S_AP_INV;
      S_AP_INV:  if (mul_done) state_nxt = S_AP_RPN;
      S_AP_RPN:  if (mul_done) state_nxt = S_AP_WR;
      S_AP_WR:   state_nxt = S_FIN;
      S_QR_RD1:  state_nxt = S_QR_RD2;
      S_QR_RD2:  state_nxt = S_QR_CAP;
      S_QR_CAP:  state_nxt = S_QR_RHI;
      S_QR_RHI:  if (mul_done) state_nxt = S_QR_RLO;
      S_QR_RLO:  if (mul_done) state_nxt = S_QR_MUL;
      S_QR_MUL:  if (mul_done) state_nxt = S_FIN;
      S_FIN:     if (can_load) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    t0_nxt = t0_r; t1_nxt = t1_r; t2_nxt = t2_r; t3_nxt = t3_r;
    rp_nxt = rp_r; binv_nxt = binv_r; inv0_nxt = inv0_r; len_nxt = len_r;
    res_hv_nxt = res_hv_r; res_st_nxt = res_st_r;
    idx_nxt = idx_r; byte_nxt = byte_r; l_nxt = l_r; rr_nxt = rr_r;
    pz_nxt = pz_r; iz_nxt = iz_r;
    out_hash_nxt = out_hash_r; out_status_nxt = out_status_r;
    out_valid_nxt = out_valid_r && out_stall;
    issued_nxt = mul_state ? (issued_r ? !mul_done : 1'b1) : 1'b0;
    mul_a = '0; mul_b = '0;
    p_en = 1'b0; p_we = 1'b0; p_addr = '0; p_wdata = '0;
    i_en = 1'b0; i_we = 1'b0; i_addr = '0; i_wdata = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          byte_nxt   = in_char_byte;
          l_nxt      = in_left_index;
          rr_nxt     = in_right_index;
          res_hv_nxt = '0;
          res_st_nxt = STS_OK;
          if (in_req_type == REQ_APPEND && len_r >= IDX_W'(MAX_LEN)) res_st_nxt = STS_FULL;
          if (in_req_type == REQ_QUERY && !q_ok) res_st_nxt = STS_RANGE;
        end
      end
      S_SB_RED: begin
        mul_a = one_m; mul_b = hash_base_r;
        if (mul_done) begin
          t0_nxt  = mul_res;
          t1_nxt  = one_m;
          idx_nxt = BIT_W'(MOD_WIDTH - 1);
        end
      end
      S_SB_SQ: begin
        mul_a = t1_r; mul_b = t1_r;
        if (mul_done) begin
          t1_nxt = mul_res;
          if (!expo[idx_r]) idx_nxt = idx_r - 1'b1;
        end
      end
      S_SB_MUL: begin
        mul_a = t1_r; mul_b = t0_r;
        if (mul_done) begin
          t1_nxt  = mul_res;
          idx_nxt = idx_r - 1'b1;
        end
      end
      S_SB_END: begin
        binv_nxt = t1_r;
        rp_nxt   = one_m;
        inv0_nxt = one_m;
        len_nxt  = '0;
      end
      S_AP_RD: begin
        p_en = 1'b1; p_addr = len_r;
        i_en = 1'b1; i_addr = len_r;
        pz_nxt = (len_r == '0);
        iz_nxt = (len_r == '0);
      end
      S_AP_CAP: begin
        t1_nxt = p_rd;
        t2_nxt = i_rd;
      end
      S_AP_RRP: begin
        mul_a = one_m; mul_b = rp_r;
        if (mul_done) t0_nxt = mul_res;
      end
      S_AP_RP1: begin
        mul_a = one_m; mul_b = t1_r;
        if (mul_done) t1_nxt = mul_res;
      end
      S_AP_RI: begin
        mul_a = one_m; mul_b = t2_r;
        if (mul_done) t2_nxt = mul_res;
      end
      S_AP_TERM: begin
        mul_a = t0_r; mul_b = {{(MOD_WIDTH-8){1'b0}}, byte_r};
        if (mul_done) t3_nxt = mul_res;
      end
      S_AP_INV: begin
        mul_a = t2_r; mul_b = binv_r;
        if (mul_done) t2_nxt = mul_res;
      end
      S_AP_RPN: begin
        mul_a = t0_r; mul_b = hash_base_r;
        if (mul_done) t0_nxt = mul_res;
      end
      S_AP_WR: begin
        p_en = 1'b1; p_we = 1'b1; p_addr = len_r + 1'b1; p_wdata = mod_add(t1_r, t3_r, m_eff);
        i_en = 1'b1; i_we = 1'b1; i_addr = len_r + 1'b1; i_wdata = t2_r;
        rp_nxt  = t0_r;
        len_nxt = len_r + 1'b1;
      end
      S_QR_RD1: begin
        p_en = 1'b1; p_addr = rr_r;
        i_en = 1'b1; i_addr = l_r;
        pz_nxt = (rr_r == '0);
        iz_nxt = (l_r == '0);
      end
      S_QR_RD2: begin
        t1_nxt = p_rd;
        t2_nxt = i_rd;
        p_en = 1'b1; p_addr = l_r - 1'b1;
        pz_nxt = (l_r == IDX_W'(1));
      end
      S_QR_CAP: t3_nxt = p_rd;
      S_QR_RHI: begin
        mul_a = one_m; mul_b = t1_r;
        if (mul_done) t1_nxt = mul_res;
      end
      S_QR_RLO: begin
        mul_a = one_m; mul_b = t3_r;
        if (mul_done) t3_nxt = mul_res;
      end
      S_QR_MUL: begin
        mul_a = mod_sub(t1_r, t3_r, m_eff); mul_b = t2_r;
        if (mul_done) res_hv_nxt = mul_res;
      end
      S_FIN: begin
        if (can_load) begin
          out_valid_nxt  = 1'b1;
          out_hash_nxt   = res_hv_r;
          out_status_nxt = res_st_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      hash_base_r    <= BASE_RESET;
      hash_modulus_r <= MOD_RESET;
      rp_r           <= MOD_WIDTH'(1);
      binv_r         <= '0;
      inv0_r         <= MOD_WIDTH'(1);
      len_r          <= '0;
      out_valid_r    <= 1'b0;
      issued_r       <= 1'b0;
      pz_r           <= 1'b0;
      iz_r           <= 1'b0;
      idx_r          <= '0;
    end else begin
      state_r     <= state_nxt;
      rp_r        <= rp_nxt;
      binv_r      <= binv_nxt;
      inv0_r      <= inv0_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
      issued_r    <= issued_nxt;
      pz_r        <= pz_nxt;
      iz_r        <= iz_nxt;
      idx_r       <= idx_nxt;
      if (cfg_wr_en) begin
        if (cfg_index == CFG_BASE) hash_base_r    <= cfg_wdata;
        if (cfg_index == CFG_MOD)  hash_modulus_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    t0_r         <= t0_nxt;
    t1_r         <= t1_nxt;
    t2_r         <= t2_nxt;
    t3_r         <= t3_nxt;
    res_hv_r     <= res_hv_nxt;
    res_st_r     <= res_st_nxt;
    out_hash_r   <= out_hash_nxt;
    out_status_r <= out_status_nxt;
    byte_r       <= byte_nxt;
    l_r          <= l_nxt;
    rr_r         <= rr_nxt;
  end

  sph_ram #(.WIDTH(MOD_WIDTH), .DEPTH(TBL_DEPTH)) u_prefix (
    .clk(clk), .en(p_en), .we(p_we), .addr(p_addr), .wdata(p_wdata), .rdata(p_q)
  );

  sph_ram #(.WIDTH(MOD_WIDTH), .DEPTH(TBL_DEPTH)) u_invpow (
    .clk(clk), .en(i_en), .we(i_we), .addr(i_addr), .wdata(i_wdata), .rdata(i_q)
  );

  sph_modmul u_mul (
    .clk(clk), .rst_n(rst_n), .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .m_i(m_eff), .done_o(mul_done), .res_o(mul_res)
  );

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;
  assign out_status     = out_status_r;

  a_wr_room: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_AP_WR |-> len_r < IDX_W'(MAX_LEN)) else $error("append past table end");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != STS_OK |-> out_hash_r == '0)
    else $error("error transaction with nonzero hash");
  a_done_issued: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> issued_r && mul_state) else $error("multiply result with no request");

endmodule
`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import sph_pkg::*;

  localparam int LIMIT_CYCLES = 4000000;

  typedef struct {
    logic [1:0]       req;
    logic [7:0]       ch;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
  } hash_req_t;

  typedef struct {
    word_t      hv;
    logic [1:0] st;
  } hash_result_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [1:0]       in_req_type;
  logic [7:0]       in_char_byte;
  logic [IDX_W-1:0] in_left_index;
  logic [IDX_W-1:0] in_right_index;
  logic             out_valid;
  logic             out_stall;
  word_t            out_hash_value;
  logic [1:0]       out_status;
  logic             cfg_wr_en;
  logic             cfg_index;
  word_t            cfg_wdata;

  substring_polynomial_hash_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .in_char_byte(in_char_byte),
    .in_left_index(in_left_index), .in_right_index(in_right_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_hash_value(out_hash_value), .out_status(out_status),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the block state.
  word_t       base_reg, mod_reg;
  word_t       prefix_sum [0:MAX_LEN];
  word_t       inv_pow [0:MAX_LEN];
  word_t       run_pow, base_inv;
  int unsigned str_len;

  hash_req_t    req_queue[$];
  hash_result_t hash_expect[$];
  int           errors = 0;
  int           results_seen = 0;
  int unsigned  cycles = 0;
  int           gen_len = 0;
  logic         in_acc = 1'b0;
  logic         out_acc = 1'b0;
  logic         burst_mode = 1'b0;
  int           in_gap = 0;
  int           out_hold = 0;
  int           long_hold = 0;
  logic         long_done = 1'b0;

  function automatic longint unsigned mul_mod(longint unsigned a, longint unsigned b,
                                              longint unsigned m);
    return ((a % m) * (b % m)) % m;
  endfunction

  function automatic longint unsigned pow_mod(longint unsigned b, longint unsigned e,
                                              longint unsigned m);
    longint unsigned acc, sq;
    acc = 1 % m;
    sq = b % m;
    while (e != 0) begin
      if (e[0]) acc = mul_mod(acc, sq, m);
      sq = mul_mod(sq, sq, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  task automatic hash_predict(input hash_req_t t);
    longint unsigned m, b, hi, lo, diff;
    hash_result_t res;
    m = (mod_reg < 2) ? 1 : mod_reg;
    b = base_reg % m;
    res.hv = '0;
    res.st = STS_OK;
    case (t.req)
      REQ_START: begin
        str_len = 0;
        run_pow = word_t'(1 % m);
        base_inv = (m < 2) ? '0 : word_t'(pow_mod(b, m - 2, m));
        prefix_sum[0] = '0;
        inv_pow[0] = word_t'(1 % m);
      end
      REQ_APPEND: begin
        if (str_len >= MAX_LEN) begin
          res.st = STS_FULL;
        end else begin
          prefix_sum[str_len+1] = word_t'((prefix_sum[str_len] % m
                                           + mul_mod(run_pow, t.ch, m)) % m);
          inv_pow[str_len+1] = word_t'(mul_mod(inv_pow[str_len], base_inv, m));
          run_pow = word_t'(mul_mod(run_pow, b, m));
          str_len++;
        end
      end
      REQ_QUERY: begin
        if (t.left < 1 || t.left > t.right || t.right > str_len) begin
          res.st = STS_RANGE;
        end else begin
          hi = prefix_sum[t.right] % m;
          lo = prefix_sum[t.left-1] % m;
          diff = (hi + m - lo) % m;
          res.hv = word_t'(mul_mod(diff, inv_pow[t.left], m));
        end
      end
      default: return;
    endcase
    hash_expect.push_back(res);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Input side: predict on every accepted transaction.
  always @(posedge clk) begin
    in_acc <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall)
      hash_predict('{in_req_type, in_char_byte, in_left_index, in_right_index});
  end

  always @(negedge clk) begin
    hash_req_t t;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_acc)) begin
      if ($urandom_range(0, 99) < 3) burst_mode = !burst_mode;
      if (in_valid) in_gap = burst_mode ? 0 : $urandom_range(0, 6);
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (req_queue.size() != 0) begin
        t = req_queue.pop_front();
        in_req_type <= t.req;
        in_char_byte <= t.ch;
        in_left_index <= t.left;
        in_right_index <= t.right;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side.
  always @(posedge clk) begin
    hash_result_t exp_res;
    out_acc <= rst_n && out_valid && !out_stall;
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (hash_expect.size() == 0) begin
        $display("%0t: unexpected result hash=%0d status=%0d", $realtime,
                 out_hash_value, out_status);
        errors++;
      end else begin
        exp_res = hash_expect.pop_front();
        if (out_hash_value !== exp_res.hv) begin
          $display("%0t: hash_value expected %0d actual %0d", $realtime,
                   exp_res.hv, out_hash_value);
          errors++;
        end
        if (out_status !== exp_res.st) begin
          $display("%0t: status expected %0d actual %0d", $realtime,
                   exp_res.st, out_status);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      // One long hold-off so that the block backs up onto its input.
      if (!long_done && results_seen == 40) begin
        long_done = 1'b1;
        long_hold = 2000;
      end
      if (out_acc) out_hold = burst_mode ? 0 : $urandom_range(0, 6);
      if (long_hold > 0) begin
        long_hold--;
        out_stall <= 1'b1;
      end else if (out_hold > 0) begin
        out_hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic push_req(input logic [1:0] req, input int ch,
                          input int l, input int r);
    hash_req_t t;
    t.req = req;
    t.ch = 8'(ch);
    t.left = IDX_W'(l);
    t.right = IDX_W'(r);
    req_queue.push_back(t);
    if (req == REQ_START) gen_len = 0;
    else if (req == REQ_APPEND && gen_len < MAX_LEN) gen_len++;
  endtask

  task automatic push_valid_query();
    int l, r;
    l = $urandom_range(1, gen_len);
    r = $urandom_range(l, gen_len);
    push_req(REQ_QUERY, $urandom, l, r);
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (req_queue.size() != 0 || in_valid || hash_expect.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input word_t val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_BASE) base_reg = val;
    else mod_reg = val;
  endtask

  task automatic random_mix(input int n);
    int sel;
    repeat (n) begin
      sel = $urandom_range(0, 99);
      if (sel < 60) push_req(REQ_APPEND, $urandom, $urandom, $urandom);
      else if (sel < 88 && gen_len > 0) push_valid_query();
      else if (sel < 94) push_req(REQ_QUERY, $urandom, $urandom_range(0, 2047),
                                  $urandom_range(0, 2047));
      else if (sel < 97) push_req(2'd3, $urandom, $urandom, $urandom);
      else push_req(REQ_START, $urandom, $urandom, $urandom);
    end
  endtask

  word_t base_tbl [10];
  word_t mod_tbl [10];

  initial begin
    base_tbl = '{31'd2147483646, 31'd1, 31'd5, 31'd3, 31'd2147483647, 31'd131,
                 31'd2, 31'd0, 31'd31, 31'd10042003};
    mod_tbl = '{31'd2147483647, 31'd2, 31'd1, 31'd0, 31'd998244353, 31'd65537,
                31'd3, 31'd257, 31'd7, 31'd1000000007};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = '0;
    in_char_byte = '0;
    in_left_index = '0;
    in_right_index = '0;
    out_stall = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_BASE;
    cfg_wdata = '0;
    base_reg = BASE_RESET;
    mod_reg = MOD_RESET;
    prefix_sum[0] = '0;
    inv_pow[0] = 1;
    run_pow = 1;
    base_inv = '0;
    str_len = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Appends ahead of any start use a zero inverse.
    push_req(REQ_APPEND, 8'h00, 0, 0);
    push_req(REQ_APPEND, 8'hFF, 0, 0);
    push_req(REQ_QUERY, 0, 1, 2);
    push_req(REQ_QUERY, 0, 2, 2);
    push_req(REQ_START, 8'hFF, 11'h7FF, 11'h7FF);
    push_req(REQ_APPEND, 8'hFF, 0, 0);
    push_req(REQ_APPEND, 8'h00, 0, 0);
    push_req(REQ_APPEND, 8'hA5, 0, 0);
    push_req(REQ_APPEND, 8'h5A, 0, 0);
    push_req(REQ_QUERY, 0, 1, 4);
    push_req(REQ_QUERY, 0, 2, 3);
    push_req(REQ_QUERY, 0, 4, 4);
    push_req(REQ_QUERY, 0, 0, 1);
    push_req(REQ_QUERY, 0, 3, 2);
    push_req(REQ_QUERY, 0, 1, 5);
    push_req(REQ_QUERY, 0, 2047, 2047);
    push_req(REQ_QUERY, 0, 1024, 1024);
    push_req(2'd3, 8'hFF, 11'h7FF, 11'h7FF);
    push_req(REQ_QUERY, 0, 1, 4);
    wait_idle();

    // Each phase changes both registers; some skip the start to exercise
    // stale table contents under a new modulus.
    for (int ph = 0; ph < 10; ph++) begin
      if ($urandom_range(0, 1)) begin
        write_reg(CFG_BASE, (ph % 3 == 0) ? word_t'($urandom) : base_tbl[ph]);
        write_reg(CFG_MOD, mod_tbl[ph]);
      end else begin
        write_reg(CFG_MOD, mod_tbl[ph]);
        write_reg(CFG_BASE, (ph % 3 == 0) ? word_t'($urandom) : base_tbl[ph]);
      end
      if (ph % 4 != 2) push_req(REQ_START, $urandom, $urandom, $urandom);
      random_mix(6);
      wait_idle();
    end

    // Fill the buffer to its limit, then push past it.
    write_reg(CFG_MOD, 31'd2147483647);
    write_reg(CFG_BASE, word_t'($urandom_range(2, 2147483646)));
    push_req(REQ_START, 0, 0, 0);
    while (gen_len < MAX_LEN) begin
      push_req(REQ_APPEND, $urandom, $urandom, $urandom);
      if ($urandom_range(0, 49) == 0) push_valid_query();
    end
    push_req(REQ_APPEND, 8'h77, 0, 0);
    push_req(REQ_APPEND, 8'hFF, 0, 0);
    push_req(REQ_QUERY, 0, 1, 1024);
    push_req(REQ_QUERY, 0, 1024, 1024);
    push_req(REQ_QUERY, 0, 1, 1);
    push_req(REQ_QUERY, 0, 1, 1025);
    push_req(REQ_QUERY, 0, 1025, 1025);
    random_mix(5);
    wait_idle();
    repeat (100) @(posedge clk);

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
